// ===== hdl/dbf_pkg.sv =====
// shared types and constants for the deblocking edge line filter
package dbf_pkg;

    localparam int SMP_W   = 16;
    localparam int TC_W    = 13;
    localparam int BD_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_BD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_BD = 1'b1;
    localparam logic [BD_W-1:0]      BD_RST        = 5'd8;

    typedef enum logic [1:0] {
        CMD_PASS   = 2'd0,
        CMD_WEAK   = 2'd1,
        CMD_STRONG = 2'd2,
        CMD_CHROMA = 2'd3
    } cmd_t;

    // smp index: 0 p2, 1 p1, 2 p0, 3 q0, 4 q1, 5 q2
    typedef struct packed {
        cmd_t                    cmd;
        logic [1:0]              side;
        logic [1:0]              byp;
        logic [TC_W-1:0]         tc;
        logic [16:0]             tc10;
        logic [5:0][SMP_W-1:0]   smp;
        logic signed [17:0]      dw;
        logic signed [16:0]      dc;
        logic signed [17:0]      hp;
        logic signed [17:0]      hq;
        logic [5:0][SMP_W-1:0]   avg;
    } s1_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [1:0]              side;
        logic [1:0]              byp;
        logic [TC_W-2:0]         ht;
        logic [5:0][SMP_W-1:0]   smp;
        logic                    wk_on;
        logic signed [13:0]      d0;
        logic signed [13:0]      dc0;
        logic signed [17:0]      hp;
        logic signed [17:0]      hq;
        logic [5:0][SMP_W-1:0]   sr;
    } s2_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [1:0]              side;
        logic [1:0]              byp;
        logic [5:0][SMP_W-1:0]   smp;
        logic                    wk_on;
        logic signed [17:0]      e0p;
        logic signed [17:0]      e0q;
        logic signed [12:0]      d1p;
        logic signed [12:0]      d1q;
        logic [5:0][SMP_W-1:0]   sr;
    } s3_t;

endpackage

// ===== hdl/dbf_delta.sv =====
// first stage: raw deltas, strong filter averages and 10*tc
module dbf_delta
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vld_in,
    input  logic [1:0]                cmd,
    input  logic [dbf_pkg::SMP_W-1:0] p3_in,
    input  logic [dbf_pkg::SMP_W-1:0] p2_in,
    input  logic [dbf_pkg::SMP_W-1:0] p1_in,
    input  logic [dbf_pkg::SMP_W-1:0] p0_in,
    input  logic [dbf_pkg::SMP_W-1:0] q0_in,
    input  logic [dbf_pkg::SMP_W-1:0] q1_in,
    input  logic [dbf_pkg::SMP_W-1:0] q2_in,
    input  logic [dbf_pkg::SMP_W-1:0] q3_in,
    input  logic [1:0]                side_flags,
    input  logic [dbf_pkg::TC_W-1:0]  tc,
    input  logic [1:0]                bypass,
    output logic                      vld,
    output dbf_pkg::s1_t              data
);
    import dbf_pkg::*;

    logic        vld_reg;
    s1_t         data_reg;
    s1_t         data_next;

    logic signed [21:0] dq0;
    logic signed [21:0] dq1;
    logic signed [21:0] wsum;
    logic signed [21:0] csum;
    logic [17:0]        pavg_sum;
    logic [17:0]        qavg_sum;
    logic [19:0]        pp3, pp2, pp1, pp0, qq0, qq1, qq2, qq3;
    logic [19:0]        s0, s1, s2, s3, s4, s5;

    always_comb
    begin
        pp3 = 20'(p3_in);
        pp2 = 20'(p2_in);
        pp1 = 20'(p1_in);
        pp0 = 20'(p0_in);
        qq0 = 20'(q0_in);
        qq1 = 20'(q1_in);
        qq2 = 20'(q2_in);
        qq3 = 20'(q3_in);

        dq0  = signed'({6'd0, q0_in}) - signed'({6'd0, p0_in});
        dq1  = signed'({6'd0, q1_in}) - signed'({6'd0, p1_in});
        // 9*(q0-p0) - 3*(q1-p1) + 8
        wsum = (dq0 <<< 3) + dq0 - ((dq1 <<< 1) + dq1) + 22'sd8;
        // 4*(q0-p0) + p1 - q1 + 4
        csum = (dq0 <<< 2) - dq1 + 22'sd4;

        pavg_sum = 18'(p2_in) + 18'(p0_in) + 18'd1;
        qavg_sum = 18'(q2_in) + 18'(q0_in) + 18'd1;

        s0 = (pp3 << 1) + (pp2 << 1) + pp2 + pp1 + pp0 + qq0 + 20'd4;
        s1 = pp2 + pp1 + pp0 + qq0 + 20'd2;
        s2 = pp2 + (pp1 << 1) + (pp0 << 1) + (qq0 << 1) + qq1 + 20'd4;
        s3 = pp1 + (pp0 << 1) + (qq0 << 1) + (qq1 << 1) + qq2 + 20'd4;
        s4 = pp0 + qq0 + qq1 + qq2 + 20'd2;
        s5 = pp0 + qq0 + qq1 + (qq2 << 1) + qq2 + (qq3 << 1) + 20'd4;

        data_next.cmd    = cmd_t'(cmd);
        data_next.side   = side_flags;
        data_next.byp    = bypass;
        data_next.tc     = tc;
        data_next.tc10   = (17'(tc) << 3) + (17'(tc) << 1);
        data_next.smp[0] = p2_in;
        data_next.smp[1] = p1_in;
        data_next.smp[2] = p0_in;
        data_next.smp[3] = q0_in;
        data_next.smp[4] = q1_in;
        data_next.smp[5] = q2_in;
        data_next.dw     = wsum[21:4];
        data_next.dc     = csum[19:3];
        data_next.hp     = signed'({1'b0, pavg_sum[17:1]}) - signed'({2'b0, p1_in});
        data_next.hq     = signed'({1'b0, qavg_sum[17:1]}) - signed'({2'b0, q1_in});
        data_next.avg[0] = s0[18:3];
        data_next.avg[1] = s1[17:2];
        data_next.avg[2] = s2[18:3];
        data_next.avg[3] = s3[18:3];
        data_next.avg[4] = s4[17:2];
        data_next.avg[5] = s5[18:3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign vld  = vld_reg;
    assign data = data_reg;

endmodule

// ===== hdl/dbf_clamp.sv =====
// second stage: tc clamps, weak activity test and strong filter limits
module dbf_clamp
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vld_in,
    input  dbf_pkg::s1_t data_in,
    output logic         vld,
    output dbf_pkg::s2_t data
);
    import dbf_pkg::*;

    logic               vld_reg;
    s2_t                data_reg;
    s2_t                data_next;

    logic [17:0]        adw;
    logic signed [13:0] stc;
    logic [13:0]        t2;
    logic signed [17:0] lo [6];
    logic signed [17:0] hi [6];
    logic signed [17:0] sa [6];

    always_comb
    begin
        adw = data_in.dw[17] ? 18'(-data_in.dw) : 18'(data_in.dw);
        stc = signed'({1'b0, data_in.tc});
        t2  = {data_in.tc, 1'b0};

        data_next.cmd   = data_in.cmd;
        data_next.side  = data_in.side;
        data_next.byp   = data_in.byp;
        data_next.ht    = data_in.tc[TC_W-1:1];
        data_next.smp   = data_in.smp;
        data_next.hp    = data_in.hp;
        data_next.hq    = data_in.hq;
        data_next.wk_on = {1'b0, data_in.tc10} > adw;

        if (data_in.dw > stc)
            data_next.d0 = stc;
        else if (data_in.dw < -stc)
            data_next.d0 = -stc;
        else
            data_next.d0 = data_in.dw[13:0];

        if (data_in.dc > stc)
            data_next.dc0 = stc;
        else if (data_in.dc < -stc)
            data_next.dc0 = -stc;
        else
            data_next.dc0 = data_in.dc[13:0];

        // hold each strong average within 2*tc of its own sample
        for (int i = 0; i < 6; i++)
        begin
            lo[i] = signed'({2'b0, data_in.smp[i]}) - signed'({4'b0, t2});
            hi[i] = signed'({2'b0, data_in.smp[i]}) + signed'({4'b0, t2});
            sa[i] = signed'({2'b0, data_in.avg[i]});
            if (sa[i] < lo[i])
                data_next.sr[i] = lo[i][15:0];
            else if (sa[i] > hi[i])
                data_next.sr[i] = hi[i][15:0];
            else
                data_next.sr[i] = data_in.avg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign vld  = vld_reg;
    assign data = data_reg;

endmodule

// ===== hdl/dbf_apply.sv =====
// third stage: edge sample updates and second-sample corrections
module dbf_apply
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vld_in,
    input  dbf_pkg::s2_t data_in,
    output logic         vld,
    output dbf_pkg::s3_t data
);
    import dbf_pkg::*;

    logic               vld_reg;
    s3_t                data_reg;
    s3_t                data_next;

    logic signed [13:0] x;
    logic signed [18:0] tp;
    logic signed [18:0] tq;
    logic signed [17:0] sp;
    logic signed [17:0] sq;
    logic signed [12:0] sht;

    always_comb
    begin
        x   = (data_in.cmd == CMD_CHROMA) ? data_in.dc0 : data_in.d0;
        tp  = 19'(data_in.hp) + 19'(data_in.d0);
        tq  = 19'(data_in.hq) - 19'(data_in.d0);
        sp  = tp[18:1];
        sq  = tq[18:1];
        sht = signed'({1'b0, data_in.ht});

        data_next.cmd   = data_in.cmd;
        data_next.side  = data_in.side;
        data_next.byp   = data_in.byp;
        data_next.smp   = data_in.smp;
        data_next.wk_on = data_in.wk_on;
        data_next.sr    = data_in.sr;
        data_next.e0p   = signed'({2'b0, data_in.smp[2]}) + 18'(x);
        data_next.e0q   = signed'({2'b0, data_in.smp[3]}) - 18'(x);

        if (sp > sht)
            data_next.d1p = sht;
        else if (sp < -sht)
            data_next.d1p = -sht;
        else
            data_next.d1p = sp[12:0];

        if (sq > sht)
            data_next.d1q = sht;
        else if (sq < -sht)
            data_next.d1q = -sht;
        else
            data_next.d1q = sq[12:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign vld  = vld_reg;
    assign data = data_reg;

endmodule

// ===== hdl/dbf_out.sv =====
// last stage: bit depth clipping, mode select, bypass and output register
module dbf_out
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           vld_in,
    input  dbf_pkg::s3_t                   data_in,
    input  logic [dbf_pkg::BD_W-1:0]       luma_bd,
    input  logic [dbf_pkg::BD_W-1:0]       chroma_bd,
    output logic                           vld,
    output logic [5:0][dbf_pkg::SMP_W-1:0] res
);
    import dbf_pkg::*;

    function automatic logic [SMP_W-1:0] depth_max(input logic [BD_W-1:0] bd);
        logic [BD_W-1:0] b;
        logic [16:0]     m;
        if (bd < 5'd8)
            b = 5'd8;
        else if (bd > 5'd16)
            b = 5'd16;
        else
            b = bd;
        m = (17'd1 << b) - 17'd1;
        return m[15:0];
    endfunction

    function automatic logic [SMP_W-1:0] clip_px(input logic signed [17:0] v,
                                                 input logic [SMP_W-1:0] mx);
        if (v < 18'sd0)
            return '0;
        else if (v > signed'({2'b0, mx}))
            return mx;
        else
            return v[15:0];
    endfunction

    logic                   vld_reg;
    logic [5:0][SMP_W-1:0]  res_reg;
    logic [5:0][SMP_W-1:0]  res_next;
    logic [SMP_W-1:0]       mx;
    logic signed [17:0]     e1p;
    logic signed [17:0]     e1q;

    always_comb
    begin
        mx  = (data_in.cmd == CMD_CHROMA) ? depth_max(chroma_bd) : depth_max(luma_bd);
        e1p = signed'({2'b0, data_in.smp[1]}) + 18'(data_in.d1p);
        e1q = signed'({2'b0, data_in.smp[4]}) + 18'(data_in.d1q);

        res_next = data_in.smp;
        case (data_in.cmd)
            CMD_WEAK:
            begin
                if (data_in.wk_on)
                begin
                    res_next[2] = clip_px(data_in.e0p, mx);
                    res_next[3] = clip_px(data_in.e0q, mx);
                    if (data_in.side[0])
                        res_next[1] = clip_px(e1p, mx);
                    if (data_in.side[1])
                        res_next[4] = clip_px(e1q, mx);
                end
            end
            CMD_STRONG:
            begin
                res_next = data_in.sr;
            end
            CMD_CHROMA:
            begin
                res_next[2] = clip_px(data_in.e0p, mx);
                res_next[3] = clip_px(data_in.e0q, mx);
            end
            default:
            begin
                res_next = data_in.smp;
            end
        endcase

        // chroma only touches p0/q0, so restoring three samples per side is exact
        if (data_in.byp[0])
        begin
            res_next[0] = data_in.smp[0];
            res_next[1] = data_in.smp[1];
            res_next[2] = data_in.smp[2];
        end
        if (data_in.byp[1])
        begin
            res_next[3] = data_in.smp[3];
            res_next[4] = data_in.smp[4];
            res_next[5] = data_in.smp[5];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign vld = vld_reg;
    assign res = res_reg;

endmodule

// ===== hdl/deblock_edge_line_filter.sv =====
// top level of the deblocking edge line filter
//
// filters one line of eight samples across a block edge per request
// input channel: in_valid/in_ready with cmd, p3_in..q3_in, side_flags, tc, bypass
// output channel: out_valid/out_ready with p2_out..q2_out
// config channel: cfg_valid/cfg_ready with cfg_index (0 luma depth, 1 chroma depth)
//   and cfg_data; cfg_ready is always high, write only while the filter is empty
// four register stages: deltas, tc clamps, sample updates, clip and output
// throughput: one request per cycle, sustained while the receiver takes results
// a stall on out_ready holds the output register; earlier stages keep moving
//   into empty slots, and in_ready drops only when every stage is full
// reset clears all stage valid bits and sets both bit depths to 8
module deblock_edge_line_filter
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [dbf_pkg::SMP_W-1:0]       p3_in,
    input  logic [dbf_pkg::SMP_W-1:0]       p2_in,
    input  logic [dbf_pkg::SMP_W-1:0]       p1_in,
    input  logic [dbf_pkg::SMP_W-1:0]       p0_in,
    input  logic [dbf_pkg::SMP_W-1:0]       q0_in,
    input  logic [dbf_pkg::SMP_W-1:0]       q1_in,
    input  logic [dbf_pkg::SMP_W-1:0]       q2_in,
    input  logic [dbf_pkg::SMP_W-1:0]       q3_in,
    input  logic [1:0]                      side_flags,
    input  logic [dbf_pkg::TC_W-1:0]        tc,
    input  logic [1:0]                      bypass,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dbf_pkg::SMP_W-1:0]       p2_out,
    output logic [dbf_pkg::SMP_W-1:0]       p1_out,
    output logic [dbf_pkg::SMP_W-1:0]       p0_out,
    output logic [dbf_pkg::SMP_W-1:0]       q0_out,
    output logic [dbf_pkg::SMP_W-1:0]       q1_out,
    output logic [dbf_pkg::SMP_W-1:0]       q2_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dbf_pkg::BD_W-1:0]        cfg_data
);
    import dbf_pkg::*;

    logic [BD_W-1:0]       luma_bd_reg;
    logic [BD_W-1:0]       chroma_bd_reg;

    logic                  v1, v2, v3, v4;
    logic                  adv1, adv2, adv3, adv4;
    s1_t                   d1;
    s2_t                   d2;
    s3_t                   d3;
    logic [5:0][SMP_W-1:0] res;

    // a stage moves when it is empty or the next one moves
    assign adv4     = !v4 || out_ready;
    assign adv3     = !v3 || adv4;
    assign adv2     = !v2 || adv3;
    assign adv1     = !v1 || adv2;
    assign in_ready = adv1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_bd_reg   <= BD_RST;
            chroma_bd_reg <= BD_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_LUMA_BD)
                luma_bd_reg <= cfg_data;
            else if (cfg_index == CFG_CHROMA_BD)
                chroma_bd_reg <= cfg_data;
        end
    end

    dbf_delta u_delta
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv1),
        .vld_in     (in_valid),
        .cmd        (cmd),
        .p3_in      (p3_in),
        .p2_in      (p2_in),
        .p1_in      (p1_in),
        .p0_in      (p0_in),
        .q0_in      (q0_in),
        .q1_in      (q1_in),
        .q2_in      (q2_in),
        .q3_in      (q3_in),
        .side_flags (side_flags),
        .tc         (tc),
        .bypass     (bypass),
        .vld        (v1),
        .data       (d1)
    );

    dbf_clamp u_clamp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv2),
        .vld_in  (v1),
        .data_in (d1),
        .vld     (v2),
        .data    (d2)
    );

    dbf_apply u_apply
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv3),
        .vld_in  (v2),
        .data_in (d2),
        .vld     (v3),
        .data    (d3)
    );

    dbf_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv4),
        .vld_in    (v3),
        .data_in   (d3),
        .luma_bd   (luma_bd_reg),
        .chroma_bd (chroma_bd_reg),
        .vld       (v4),
        .res       (res)
    );

    assign out_valid = v4;
    assign p2_out    = res[0];
    assign p1_out    = res[1];
    assign p0_out    = res[2];
    assign q0_out    = res[3];
    assign q1_out    = res[4];
    assign q2_out    = res[5];

endmodule
